[src/lfu_pkg.sv]
package lfu_pkg;
  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic update;
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lfu_stat_t;
endpackage

[src/lfu_req_if.sv]
interface lfu_req_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  logic req_type;
  logic [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] write_value;
  modport source (output valid, req_type, key, write_value, input ready);
  modport sink (input valid, req_type, key, write_value, output ready);
endinterface

[src/lfu_rsp_if.sv]
interface lfu_rsp_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  logic signed [VAL_W-1:0] read_value;
  logic evicted;
  logic [KEY_W-1:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[src/lfu_cfg_if.sv]
interface lfu_cfg_if;
  import lfu_pkg::*;
  logic valid;
  logic ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/lfu_ctrl.sv]
module lfu_ctrl import lfu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lfu_cmd_t  cmd,
  input  lfu_stat_t stat
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

[src/lfu_dp.sv]
module lfu_dp import lfu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lfu_cmd_t                cmd,
  output lfu_stat_t               stat,
  input  logic [CAP_W-1:0]        capacity,
  input  logic                    req_type,
  input  logic [KEY_W-1:0]        key,
  input  logic signed [VAL_W-1:0] write_value,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  output logic [KEY_W-1:0]        evicted_key
);
  logic [ENTRIES-1:0]    vld;
  logic [KEY_W-1:0]      ekey [ENTRIES];
  logic [VAL_W-1:0]      eval [ENTRIES];
  logic [COUNT_BITS-1:0] cnt  [ENTRIES];
  logic [IDX_W-1:0]      rank [ENTRIES];
  logic [OCC_W-1:0]      occ;

  logic              r_put;
  logic [KEY_W-1:0]  r_key;
  logic [VAL_W-1:0]  r_val;
  logic [OCC_W-1:0]  cap;

  // sequential scan state: one entry per cycle
  logic [IDX_W-1:0]      idx;
  logic                  f_hit, f_free, f_vic;
  logic [IDX_W-1:0]      hit_i, free_i, vic_i;
  logic [COUNT_BITS-1:0] vic_cnt;
  logic [IDX_W-1:0]      vic_rank;

  assign stat.scan_last = (idx == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_put <= req_type;
      r_key <= key;
      r_val <= write_value;
      cap <= (capacity > CAP_W'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
      f_hit <= 1'b0;
      f_free <= 1'b0;
      f_vic <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (vld[idx]) begin
        if (!f_hit && ekey[idx] == r_key) begin
          f_hit <= 1'b1;
          hit_i <= idx;
        end
        if (!f_vic || cnt[idx] < vic_cnt ||
            (cnt[idx] == vic_cnt && rank[idx] > vic_rank)) begin
          f_vic <= 1'b1;
          vic_i <= idx;
          vic_cnt <= cnt[idx];
          vic_rank <= rank[idx];
        end
      end else if (!f_free) begin
        f_free <= 1'b1;
        free_i <= idx;
      end
    end
  end

  logic              en, do_hit, do_ins, do_ev;
  logic [IDX_W-1:0]  ins_i;
  logic [IDX_W-1:0]  hrank;
  always_comb begin
    en = (cap != '0);
    do_hit = en && f_hit;
    do_ev = en && !f_hit && r_put && (occ >= cap || !f_free) && f_vic;
    do_ins = en && !f_hit && r_put && (do_ev || f_free);
    // after evicting, the lowest free slot is the smaller of the two
    ins_i = free_i;
    if (do_ev && (!f_free || vic_i < free_i)) ins_i = vic_i;
    hrank = rank[hit_i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        cnt[j] <= '0;
        rank[j] <= '0;
      end
    end else if (cmd.update) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (do_hit) begin
          if (IDX_W'(j) == hit_i) begin
            rank[j] <= '0;
            if (cnt[j] != COUNT_TOP) cnt[j] <= cnt[j] + 1'b1;
            if (r_put) eval[j] <= r_val;
          end else if (vld[j] && rank[j] < hrank) begin
            rank[j] <= rank[j] + 1'b1;
          end
        end else if (do_ins) begin
          if (IDX_W'(j) == ins_i) begin
            vld[j] <= 1'b1;
            ekey[j] <= r_key;
            eval[j] <= r_val;
            cnt[j] <= COUNT_BITS'(1);
            rank[j] <= '0;
          end else if (do_ev && IDX_W'(j) == vic_i) begin
            vld[j] <= 1'b0;
            cnt[j] <= '0;
            rank[j] <= '0;
          end else if (vld[j]) begin
            // drop shifts older ones down, insert shifts all up
            if (do_ev && rank[j] > vic_rank) rank[j] <= rank[j];
            else rank[j] <= rank[j] + 1'b1;
          end
        end
      end
      if (do_ins && !do_ev) occ <= occ + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit <= do_hit;
      read_value <= do_hit ? (r_put ? r_val : eval[hit_i]) : '0;
      evicted <= do_ev;
      evicted_key <= do_ev ? ekey[vic_i] : '0;
    end
  end
endmodule

[src/lfu_cache_replacement.sv]
// flow: a request is taken only when idle, then a 16-entry scan, the update,
//   and the result is held valid until taken; no new request is taken before that
// scan: one entry per cycle through a single compare unit
// reset: synchronous; all entries invalid, counts and ranks zero, capacity 16
module lfu_cache_replacement import lfu_pkg::*; (
  input logic   clk,
  input logic   rst,
  lfu_cfg_if.sink   cfg,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);
  lfu_cmd_t  cmd;
  lfu_stat_t stat;
  logic [CAP_W-1:0] capacity;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (cfg.valid) capacity <= cfg.data;
  end

  lfu_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd), .stat(stat)
  );

  lfu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .capacity(capacity),
    .req_type(req.req_type), .key(req.key), .write_value(req.write_value),
    .hit(rsp.hit), .read_value(rsp.read_value),
    .evicted(rsp.evicted), .evicted_key(rsp.evicted_key)
  );
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
  import lfu_pkg::*;

  typedef struct packed {
    logic is_put;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] wval;
  } request_t;

  typedef struct packed {
    logic hit;
    logic [VAL_W-1:0] rval;
    logic evicted;
    logic [KEY_W-1:0] ekey;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  lfu_cfg_if cfg_ch ();
  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_cache_replacement dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  // shadow of the cache contents
  logic                  sh_valid [ENTRIES];
  logic [KEY_W-1:0]      sh_key   [ENTRIES];
  logic [VAL_W-1:0]      sh_val   [ENTRIES];
  logic [COUNT_BITS-1:0] sh_count [ENTRIES];
  int unsigned           sh_rank  [ENTRIES];
  int unsigned           sh_occ;
  int unsigned           sh_cap;

  request_t  pending_reqs [$];
  response_t expected_rsps [$];
  logic [KEY_W-1:0] key_pool [$];
  int  errors = 0;
  bit  quiet = 0;
  bit  hold_rsp = 0;
  int  req_idle = 0, rsp_idle = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  function automatic response_t lfu_predict(request_t r);
    response_t o;
    int i, j, f, v, cap;
    int unsigned rk;
    o = '0;
    cap = (sh_cap > ENTRIES) ? ENTRIES : sh_cap;
    if (cap == 0) return o;
    i = -1;
    for (j = 0; j < ENTRIES; j++)
      if (i < 0 && sh_valid[j] && sh_key[j] == r.key) i = j;
    if (i >= 0) begin
      if (r.is_put) sh_val[i] = r.wval;
      rk = sh_rank[i];
      for (j = 0; j < ENTRIES; j++)
        if (j != i && sh_valid[j] && sh_rank[j] < rk) sh_rank[j]++;
      sh_rank[i] = 0;
      if (sh_count[i] != COUNT_TOP) sh_count[i]++;
      o.hit = 1'b1;
      o.rval = sh_val[i];
    end else if (r.is_put) begin
      f = -1;
      for (j = 0; j < ENTRIES; j++)
        if (f < 0 && !sh_valid[j]) f = j;
      if (sh_occ >= cap || f < 0) begin
        v = -1;
        for (j = 0; j < ENTRIES; j++)
          if (sh_valid[j] && (v < 0 || sh_count[j] < sh_count[v] ||
              (sh_count[j] == sh_count[v] && sh_rank[j] > sh_rank[v]))) v = j;
        if (v >= 0) begin
          o.evicted = 1'b1;
          o.ekey = sh_key[v];
          rk = sh_rank[v];
          for (j = 0; j < ENTRIES; j++)
            if (j != v && sh_valid[j] && sh_rank[j] > rk) sh_rank[j]--;
          sh_valid[v] = 1'b0;
          sh_count[v] = '0;
          sh_rank[v] = 0;
          if (sh_occ > 0) sh_occ--;
        end
        f = -1;
        for (j = 0; j < ENTRIES; j++)
          if (f < 0 && !sh_valid[j]) f = j;
      end
      if (f >= 0) begin
        for (j = 0; j < ENTRIES; j++)
          if (sh_valid[j]) sh_rank[j]++;
        sh_valid[f] = 1'b1;
        sh_key[f] = r.key;
        sh_val[f] = r.wval;
        sh_count[f] = 1;
        sh_rank[f] = 0;
        sh_occ++;
      end
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_idle <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(lfu_predict({req_ch.req_type, req_ch.key, req_ch.write_value}));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_idle > 0) begin
          req_idle <= req_idle - 1;
          req_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          req_idle <= $urandom_range(0, 10);
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= r.is_put;
          req_ch.key <= r.key;
          req_ch.write_value <= r.wval;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_idle <= 0;
      hold_left <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response transfer");
          errors++;
        end else begin
          response_t e;
          e = expected_rsps.pop_front();
          if (rsp_ch.hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, rsp_ch.hit); errors++;
          end
          if (rsp_ch.read_value !== e.rval) begin
            $error("read_value: expected %0h actual %0h", e.rval, rsp_ch.read_value);
            errors++;
          end
          if (rsp_ch.evicted !== e.evicted) begin
            $error("evicted: expected %0d actual %0d", e.evicted, rsp_ch.evicted); errors++;
          end
          if (rsp_ch.evicted_key !== e.ekey) begin
            $error("evicted_key: expected %0h actual %0h", e.ekey, rsp_ch.evicted_key);
            errors++;
          end
        end
      end
      if (hold_rsp && hold_left == 0) begin
        hold_left <= 2000;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= (hold_left == 1);
      end else if (rsp_idle > 0) begin
        rsp_idle <= rsp_idle - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_idle <= $urandom_range(0, 10);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic add_req(logic is_put, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    pending_reqs.push_back({is_put, k, v});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_cap(logic [CAP_W-1:0] c);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sh_cap = c;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int pool_size);
    int k;
    key_pool.delete();
    for (k = 0; k < pool_size; k++) key_pool.push_back($urandom());
    for (k = 0; k < n; k++)
      add_req($urandom_range(0, 1), pick_key(), $urandom());
  endtask

  initial begin
    int k;
    logic [CAP_W-1:0] caps [7] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd4, 5'd17, 5'd9};
    for (k = 0; k < ENTRIES; k++) begin
      sh_valid[k] = 0; sh_key[k] = 0; sh_val[k] = 0; sh_count[k] = 0; sh_rank[k] = 0;
    end
    sh_occ = 0;
    sh_cap = CAP_RESET;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.key = '0;
    req_ch.write_value = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, miss, hit, overwrite, fill and evict ties
    add_req(REQ_GET, 32'h0, 32'h0);
    add_req(REQ_PUT, 32'h0, 32'h8000_0000);
    add_req(REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    add_req(REQ_PUT, 32'h0, 32'hFFFF_FFFF);
    add_req(REQ_GET, 32'h0, 32'h1234_5678);
    for (k = 0; k < 16; k++) add_req(REQ_PUT, 32'h100 + k, k);
    add_req(REQ_GET, 32'h100, 32'h0);
    drain();

    // capacity zero hides entries
    write_cap(5'd0);
    add_req(REQ_GET, 32'h0, 32'h0);
    add_req(REQ_PUT, 32'h55, 32'h1);
    drain();
    // lower capacity below occupancy
    write_cap(5'd2);
    add_req(REQ_PUT, 32'h77, 32'h2);
    add_req(REQ_GET, 32'h0, 32'h0);
    drain();

    // receiver holds off while the sender keeps offering
    write_cap(5'd16);
    hold_rsp = 1;
    random_phase(40, 24);
    repeat (3) @(posedge clk);
    hold_rsp = 0;
    drain();

    for (k = 0; k < 7; k++) begin
      write_cap(caps[k]);
      random_phase(200, (k % 2) ? 12 : 40);
      drain();
    end

    // repeated hits on one key
    write_cap(5'd16);
    add_req(REQ_PUT, 32'hC0FFEE, 32'h1);
    for (k = 0; k < 10; k++) pending_reqs.push_back({REQ_GET, 32'hC0FFEE, 32'h0});
    drain();

    quiet = 1;
    random_phase(100, 20);
    add_req(REQ_GET, 32'hC0FFEE, 32'h0);
    drain();

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

[files.f]
src/lfu_pkg.sv
src/lfu_req_if.sv
src/lfu_rsp_if.sv
src/lfu_cfg_if.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_replacement.sv
bench/tb.sv
